>>> sv/service_lifecycle_monitor_core_defines.svh
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef SERVICE_LIFECYCLE_MONITOR_CORE_DEFINES_SVH
`define SERVICE_LIFECYCLE_MONITOR_CORE_DEFINES_SVH
// Assert that an antecedent implies a consequent on the next clock.
`define SLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slm check failed");
// Assert that an antecedent implies a consequent on the same clock.
`define SLM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slm check failed");
`endif

>>> sv/slm_pkg.sv
// Package for the service lifecycle monitor: beat types, codes, defaults.
// No dependencies.
`default_nettype none
package slm_pkg;
  localparam int unsigned CoresDefault = 4;
  localparam int unsigned SlotsDefault = 16;

  typedef enum logic [3:0] {
    ACT_INIT = 4'd0, ACT_REG = 4'd1, ACT_BEGIN = 4'd2, ACT_END = 4'd3,
    ACT_MARK = 4'd4, ACT_PAUSE = 4'd5, ACT_RESUME = 4'd6, ACT_RESTART = 4'd7,
    ACT_QUERY = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    LS_EMPTY = 3'd0, LS_REG = 3'd1, LS_RUN = 3'd2, LS_PAUSE = 3'd3, LS_FAULT = 3'd4
  } life_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_READ, ST_EXEC, ST_WRITE, ST_OUT
  } fsm_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] svc_id;
    logic [31:0] kind;
    logic [31:0] priority_req;
    logic [63:0] run_start;
    logic [63:0] run_end;
    logic        error_flag;
    logic [31:0] fault_code;
  } in_beat_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] result_id;
    logic [2:0]  life_state;
    logic [31:0] kind_out;
    logic [31:0] priority_out;
    logic [63:0] calls_out;
    logic [63:0] errors_out;
    logic [63:0] total_ticks_out;
    logic [63:0] last_duration_out;
    logic [63:0] max_duration_out;
    logic [63:0] restarts_out;
    logic [31:0] last_error_out;
  } out_beat_t;

  // Lifecycle state and statistics of one slot, one memory word.
  typedef struct packed {
    life_t       life;
    logic [31:0] kind;
    logic [31:0] prio;
    logic [63:0] calls;
    logic [63:0] errors;
    logic [63:0] total;
    logic [63:0] last_dur;
    logic [63:0] max_dur;
    logic [63:0] restarts;
    logic [31:0] last_err;
  } stats_t;
endpackage
`default_nettype wire

>>> sv/service_lifecycle_monitor_core.sv
// Service lifecycle monitor. Slot state and statistics sit in one memory word per slot;
// each beat is a read, one pass through a 64-bit subtractor and the update logic, and
// a write when the slot is hit. The FSM steps IDLE, SCAN, READ, EXEC, WRITE, OUT; register
// and init_core scan the core's slots one per cycle in SCAN. A new beat is taken only in
// IDLE, after the last result has been taken, so output stalls hold the block. Reset
// clears the used bits at once (flip-flops); no clearing pass.
`default_nettype none
module service_lifecycle_monitor_core import slm_pkg::*; #(
  parameter int unsigned CORES = CoresDefault,
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);
  localparam int unsigned NSLOT = CORES * SLOTS;
  localparam int unsigned IW = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int unsigned SW = $clog2(SLOTS + 1);

  fsm_t state, state_next;
  in_beat_t req;
  stats_t mem [NSLOT];
  stats_t rd, wr;
  logic [NSLOT-1:0] used;
  logic [IW-1:0] idx;
  logic [SW-1:0] scan;
  logic hit;
  out_beat_t res;
  logic [63:0] dur;
  // duration unit: a 65-bit subtract of run_start from run_end
  logic [64:0] diff;

  logic [7:0] core;
  logic [7:0] slot;
  logic core_ok, slot_ok;
  assign core = req.svc_id[15:8];
  assign slot = req.svc_id[7:0];
  assign core_ok = 32'(core) < CORES;
  assign slot_ok = 32'(slot) < SLOTS;
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: begin
        if (req.action == ACT_INIT || req.action == ACT_REG) begin
          if (!core_ok || 32'(scan) >= SLOTS - 1 || req.action == ACT_REG && !used[idx])
            state_next = ST_READ;
        end else state_next = ST_READ;
      end
      ST_READ:  state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_WRITE;
      ST_WRITE: state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory read, registered; memory write on a hit in WRITE.
  always_ff @(posedge clk) begin
    if (state == ST_READ) rd <= mem[idx];
    if (state == ST_WRITE && hit) mem[idx] <= wr;
  end

  // Duration unit: the difference is registered in EXEC, clamped to zero on a borrow.
  always_comb diff = {1'b0, req.run_end} - {1'b0, req.run_start};

  // Clear used bits on init_core, set them on register.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      case (state)
        ST_SCAN: begin
          if (req.action == ACT_INIT && core_ok) used[idx] <= 1'b0;
        end
        ST_WRITE: begin
          if (hit && req.action == ACT_REG) used[idx] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (in_valid) begin
        req <= in_data;
        scan <= '0;
      end
      ST_SCAN: begin
        hit <= 1'b0;
        if (req.action == ACT_INIT || req.action == ACT_REG) begin
          if (core_ok && 32'(scan) < SLOTS - 1 &&
              !(req.action == ACT_REG && !used[idx])) begin
            scan <= scan + SW'(1);
            idx <= idx + IW'(1);
          end else if (req.action == ACT_REG && core_ok && !used[idx]) hit <= 1'b1;
        end else if (core_ok && slot_ok && used[idx] && req.action <= ACT_QUERY) begin
          hit <= 1'b1;
        end
      end
      ST_EXEC: begin
        dur <= diff[64] ? 64'd0 : diff[63:0];
      end
      default: ;
    endcase
    if (state == ST_IDLE && in_valid) begin
      idx <= IW'(32'(in_data.svc_id[15:8]) * SLOTS
             + ((in_data.action == ACT_INIT || in_data.action == ACT_REG) ? 32'd0
                : 32'(in_data.svc_id[7:0])));
    end
  end

  // Compute new slot contents and the result beat.
  always_comb begin
    life_t lf;
    logic ok;
    lf = rd.life;
    wr = rd;
    ok = hit;
    if (req.action == ACT_REG) begin
      wr = '0;
      wr.kind = req.kind;
      wr.prio = req.priority_req;
      lf = LS_REG;
    end
    unique case (req.action)
      ACT_BEGIN: if (lf != LS_PAUSE && lf != LS_FAULT) lf = LS_RUN;
      ACT_END: begin
        wr.calls = rd.calls + 64'd1;
        wr.total = rd.total + dur;
        wr.last_dur = dur;
        if (dur > rd.max_dur) wr.max_dur = dur;
        if (req.error_flag) begin
          wr.errors = rd.errors + 64'd1;
          lf = LS_FAULT;
        end else if (lf == LS_RUN) lf = LS_REG;
      end
      ACT_MARK: begin
        wr.errors = rd.errors + 64'd1;
        wr.last_err = req.fault_code;
        lf = LS_FAULT;
      end
      ACT_PAUSE: if (lf == LS_FAULT) ok = 1'b0; else lf = LS_PAUSE;
      ACT_RESUME: if (lf != LS_PAUSE) ok = 1'b0; else lf = LS_REG;
      ACT_RESTART: begin
        wr.last_err = '0;
        wr.restarts = rd.restarts + 64'd1;
        lf = LS_REG;
      end
      default: ;
    endcase
    wr.life = lf;
    res = '0;
    res.result_id = req.svc_id;
    if (req.action == ACT_INIT) res.ok = core_ok;
    else if (hit) begin
      res.ok = ok;
      if (req.action == ACT_REG) res.result_id = {core, 8'(scan)};
      res.life_state = lf;
      res.kind_out = wr.kind;
      res.priority_out = wr.prio;
      res.calls_out = wr.calls;
      res.errors_out = wr.errors;
      res.total_ticks_out = wr.total;
      res.last_duration_out = wr.last_dur;
      res.max_duration_out = wr.max_dur;
      res.restarts_out = wr.restarts;
      res.last_error_out = wr.last_err;
    end
  end

  // Hold the result beat until taken.
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) out_data <= res;
  end
  assign out_valid = (state == ST_OUT);
endmodule
`default_nettype wire

>>> sv/slm_checker.sv
// Port-level checker for the service lifecycle monitor, bound to the top level.
// Depends on slm_pkg and the defines header.
`default_nettype none
`include "service_lifecycle_monitor_core_defines.svh"
module slm_checker import slm_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_beat_t out_data
);
  // No new beat is taken while a result waits.
  `SLM_ASSERT_NOW(a_busy, clk, rst, out_valid, !in_ready)
  // An accepted beat leaves the block busy.
  `SLM_ASSERT_NEXT(a_accept, clk, rst, in_valid && in_ready, !in_ready)
  // A stalled result holds.
  `SLM_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  // A result that shows the slot as empty carries a zero call count.
  `SLM_ASSERT_NOW(a_empty, clk, rst, out_valid && out_data.life_state == LS_EMPTY,
                  out_data.calls_out == 64'd0)
endmodule

bind service_lifecycle_monitor_core slm_checker u_slm_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
